// ===== hw/rtl/hsi_to_rgb_converter_defines.svh =====
// assertion macros shared by the hsi to rgb converter rtl
`ifndef HSI_TO_RGB_CONVERTER_DEFINES_SVH
`define HSI_TO_RGB_CONVERTER_DEFINES_SVH
`ifndef SYNTHESIS
// plain property checked on every rising clock edge out of reset
`define H2R_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hsi to rgb check failed");
// implication checked on every rising clock edge out of reset
`define H2R_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsi to rgb implication failed");
`else
`define H2R_ASSERT(lbl, clk, rst_n, prop)
`define H2R_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/hsi2rgb_pkg.sv =====
// shared widths, sector codes and inter-stage word types
package hsi2rgb_pkg;

  localparam int unsigned CH_W   = 16;
  localparam int unsigned H6_W   = 19;
  localparam int unsigned SF_W   = 32;
  localparam int unsigned FAC_W  = 34;
  localparam int unsigned PROD_W = 51;

  localparam logic [CH_W-1:0]          ONE_Q15  = 16'h8000;
  localparam logic signed [FAC_W-1:0]  ONE_Q31  = 34'sh0_8000_0000;
  localparam logic signed [PROD_W-1:0] HALF_Q31 = 51'sh0_4000_0000;

  // hexcone sector, named by the colours it spans
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // word leaving the front end: sector, s, i and s*f
  typedef struct packed {
    sector_e           sector;
    logic [CH_W-1:0]   sat;
    logic [CH_W-1:0]   inten;
    logic [SF_W-1:0]   sf;
  } front_t;

  // word leaving the multiplier stage: the three raw products
  typedef struct packed {
    sector_e                   sector;
    logic [CH_W-1:0]           inten;
    logic signed [PROD_W-1:0]  p;
    logic signed [PROD_W-1:0]  q;
    logic signed [PROD_W-1:0]  t;
  } chan_prod_t;

endpackage

// ===== hw/rtl/hsi2rgb_front.sv =====
// front end: hue times six, sector split and the s*f product
`include "hsi_to_rgb_converter_defines.svh"
module hsi2rgb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          hue_i,
  input  logic [15:0]          saturation_i,
  input  logic [15:0]          intensity_i,
  output logic                 front_valid_o,
  input  logic                 front_ready_i,
  output hsi2rgb_pkg::front_t  front_o
);

  logic                                a_v_q;
  logic [hsi2rgb_pkg::H6_W-1:0]        a_h6_q;
  logic [hsi2rgb_pkg::CH_W-1:0]        a_s_q;
  logic [hsi2rgb_pkg::CH_W-1:0]        a_i_q;
  logic [hsi2rgb_pkg::H6_W-1:0]        a_h6_d;
  logic                                a_ld;
  logic                                b_v_q;
  hsi2rgb_pkg::front_t                 b_q;
  logic                                b_ld;

  // stage load enables, a stage moves when empty or drained downstream
  assign b_ld       = !b_v_q || front_ready_i;
  assign a_ld       = !a_v_q || b_ld;
  assign in_ready_o = a_ld;

  // hue times six as 4h + 2h
  assign a_h6_d = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};

  // stage a: scaled hue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_ld) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ld && in_valid_i) begin
      a_h6_q <= a_h6_d;
      a_s_q  <= saturation_i;
      a_i_q  <= intensity_i;
    end
  end

  // stage b: sector and s*f
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_ld) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ld && a_v_q) begin
      b_q.sector <= hsi2rgb_pkg::sector_e'(a_h6_q[hsi2rgb_pkg::H6_W-1:16]);
      b_q.sat    <= a_s_q;
      b_q.inten  <= a_i_q;
      b_q.sf     <= {16'h0000, a_s_q} * {16'h0000, a_h6_q[15:0]};
    end
  end

  assign front_valid_o = b_v_q;
  assign front_o       = b_q;

  // hue times six stays below six full turns
  `H2R_ASSERT_IMP(a_sector_bound, clk_i, rst_ni, b_v_q, b_q.sector <= hsi2rgb_pkg::SEC_MAG_RED)

endmodule

// ===== hw/rtl/hsi2rgb_mul.sv =====
// factor forming and the three intensity products
module hsi2rgb_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     front_valid_i,
  output logic                     front_ready_o,
  input  hsi2rgb_pkg::front_t      front_i,
  output logic                     prod_valid_o,
  input  logic                     prod_ready_i,
  output hsi2rgb_pkg::chan_prod_t  prod_o
);

  logic                                      c_v_q;
  hsi2rgb_pkg::sector_e                      c_sector_q;
  logic [hsi2rgb_pkg::CH_W-1:0]              c_i_q;
  logic signed [hsi2rgb_pkg::FAC_W-1:0]      c_fp_q;
  logic signed [hsi2rgb_pkg::FAC_W-1:0]      c_fq_q;
  logic signed [hsi2rgb_pkg::FAC_W-1:0]      c_ft_q;
  logic signed [hsi2rgb_pkg::FAC_W-1:0]      s_hi;
  logic signed [hsi2rgb_pkg::FAC_W-1:0]      sf_ext;
  logic signed [hsi2rgb_pkg::CH_W:0]         i_sgn;
  logic                                      c_ld;
  logic                                      d_v_q;
  hsi2rgb_pkg::chan_prod_t                   d_q;
  logic                                      d_ld;

  assign d_ld          = !d_v_q || prod_ready_i;
  assign c_ld          = !c_v_q || d_ld;
  assign front_ready_o = c_ld;

  // s in q1.31 and s*f widened to the factor width
  assign s_hi   = signed'({2'b00, front_i.sat, 16'h0000});
  assign sf_ext = signed'({2'b00, front_i.sf});

  // stage c: 1-s, 1-s*f and 1-s*(1-f) in q1.31
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (c_ld) begin
      c_v_q <= front_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ld && front_valid_i) begin
      c_sector_q <= front_i.sector;
      c_i_q      <= front_i.inten;
      c_fp_q     <= hsi2rgb_pkg::ONE_Q31 - s_hi;
      c_fq_q     <= hsi2rgb_pkg::ONE_Q31 - sf_ext;
      c_ft_q     <= hsi2rgb_pkg::ONE_Q31 - s_hi + sf_ext;
    end
  end

  // stage d: intensity times each factor
  assign i_sgn = signed'({1'b0, c_i_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (d_ld) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ld && c_v_q) begin
      d_q.sector <= c_sector_q;
      d_q.inten  <= c_i_q;
      d_q.p      <= hsi2rgb_pkg::PROD_W'(i_sgn) * hsi2rgb_pkg::PROD_W'(c_fp_q);
      d_q.q      <= hsi2rgb_pkg::PROD_W'(i_sgn) * hsi2rgb_pkg::PROD_W'(c_fq_q);
      d_q.t      <= hsi2rgb_pkg::PROD_W'(i_sgn) * hsi2rgb_pkg::PROD_W'(c_ft_q);
    end
  end

  assign prod_valid_o = d_v_q;
  assign prod_o       = d_q;

endmodule

// ===== hw/rtl/hsi2rgb_out.sv =====
// rounding, clamping and sector selection into the output register
module hsi2rgb_out (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     prod_valid_i,
  output logic                     prod_ready_o,
  input  hsi2rgb_pkg::chan_prod_t  prod_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [15:0]              red_o,
  output logic [15:0]              green_o,
  output logic [15:0]              blue_o
);

  // q2.46 product back to q1.15, round half up, clamp to 0..1
  function automatic logic [hsi2rgb_pkg::CH_W-1:0] round_sat(
    input logic signed [hsi2rgb_pkg::PROD_W-1:0] prod
  );
    logic signed [hsi2rgb_pkg::PROD_W-1:0] rnd;
    logic [hsi2rgb_pkg::CH_W-1:0]          res;
    rnd = prod + hsi2rgb_pkg::HALF_Q31;
    if (prod <= 0) begin
      res = '0;
    end else if (rnd[hsi2rgb_pkg::PROD_W-1:31] >
                 {4'h0, hsi2rgb_pkg::ONE_Q15}) begin
      res = hsi2rgb_pkg::ONE_Q15;
    end else begin
      res = rnd[46:31];
    end
    return res;
  endfunction

  logic                          e_v_q;
  logic                          e_ld;
  logic [hsi2rgb_pkg::CH_W-1:0]  red_q, green_q, blue_q;
  logic [hsi2rgb_pkg::CH_W-1:0]  red_d, green_d, blue_d;
  logic [hsi2rgb_pkg::CH_W-1:0]  iv, pv, qv, tv;

  assign e_ld         = !e_v_q || out_ready_i;
  assign prod_ready_o = e_ld;

  // channel candidates
  assign iv = (prod_i.inten > hsi2rgb_pkg::ONE_Q15) ? hsi2rgb_pkg::ONE_Q15
                                                    : prod_i.inten;
  assign pv = round_sat(prod_i.p);
  assign qv = round_sat(prod_i.q);
  assign tv = round_sat(prod_i.t);

  // hexcone selection by sector
  always_comb begin
    unique case (prod_i.sector)
      hsi2rgb_pkg::SEC_RED_YEL: begin red_d = iv; green_d = tv; blue_d = pv; end
      hsi2rgb_pkg::SEC_YEL_GRN: begin red_d = qv; green_d = iv; blue_d = pv; end
      hsi2rgb_pkg::SEC_GRN_CYN: begin red_d = pv; green_d = iv; blue_d = tv; end
      hsi2rgb_pkg::SEC_CYN_BLU: begin red_d = pv; green_d = qv; blue_d = iv; end
      hsi2rgb_pkg::SEC_BLU_MAG: begin red_d = tv; green_d = pv; blue_d = iv; end
      default:                  begin red_d = iv; green_d = pv; blue_d = qv; end
    endcase
  end

  // stage e: output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (e_ld) begin
      e_v_q <= prod_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_ld && prod_valid_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = e_v_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

// ===== hw/rtl/hsi_to_rgb_converter.sv =====
// top level of the hsi to rgb pixel converter
//
// Converts one hue/saturation/intensity word per clock, if not stalled,
// into red, green and blue. Hue is an unsigned fraction of a full turn;
// saturation, intensity and the outputs are q1.15, 0x8000 meaning one.
// Input channel: in_valid_i/in_ready_o with hue_i, saturation_i and
// intensity_i. Output channel: out_valid_o/out_ready_i with red_o,
// green_o and blue_o. A word moves when valid and ready are both high.
// Pipeline: five register stages, in order hue scaling, s*f multiply,
// factor forming, intensity multiply and round/select.
// Throughput: one word per cycle while out_ready_i is high; each stage
// holds one word and loads when empty or when its successor takes it.
// Reset: all stage valid bits clear, the pipeline is empty and
// in_ready_o is high.
// Receiver stall: words hold in place, empty stages still fill, and
// in_ready_o drops only once all five stages carry a word.
`include "hsi_to_rgb_converter_defines.svh"
module hsi_to_rgb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] hue_i,
  input  logic [15:0] saturation_i,
  input  logic [15:0] intensity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] red_o,
  output logic [15:0] green_o,
  output logic [15:0] blue_o
);

  logic                     front_valid;
  logic                     front_ready;
  hsi2rgb_pkg::front_t      front_word;
  logic                     prod_valid;
  logic                     prod_ready;
  hsi2rgb_pkg::chan_prod_t  prod_word;

  // hue scaling and s*f
  hsi2rgb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .hue_i         (hue_i),
    .saturation_i  (saturation_i),
    .intensity_i   (intensity_i),
    .front_valid_o (front_valid),
    .front_ready_i (front_ready),
    .front_o       (front_word)
  );

  // factors and intensity products
  hsi2rgb_mul u_mul (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .front_valid_i (front_valid),
    .front_ready_o (front_ready),
    .front_i       (front_word),
    .prod_valid_o  (prod_valid),
    .prod_ready_i  (prod_ready),
    .prod_o        (prod_word)
  );

  // rounding, clamping, selection and output register
  hsi2rgb_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod_word),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  // outputs never exceed one
  `H2R_ASSERT_IMP(a_out_range, clk_i, rst_ni, out_valid_o, (red_o <= hsi2rgb_pkg::ONE_Q15) && (green_o <= hsi2rgb_pkg::ONE_Q15) && (blue_o <= hsi2rgb_pkg::ONE_Q15))
  // a ready receiver lets the whole pipeline advance
  `H2R_ASSERT_IMP(a_ready_flows, clk_i, rst_ni, out_ready_i, in_ready_o)
  // back pressure only appears behind a stalled full output
  `H2R_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

endmodule
